FILE: src/rabin_pkg.sv
// rabin_pkg: shared types, codes and constants for the offset Rabin cipher block.
// No dependencies; used by rabin_alu, rabin_core and rabin_encrypt_decrypt.
`timescale 1ns / 1ps

package rabin_pkg;

  localparam int VALUE_W   = 24;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_P  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_Q  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B = 2'd2;

  localparam int PRIME_P_RST  = 3;
  localparam int PRIME_Q_RST  = 7;
  localparam int OFFSET_B_RST = 0;

  localparam logic CMD_ENCRYPT = 1'b0;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] first_out;
    logic [VALUE_W-1:0] second_out;
    logic [VALUE_W-1:0] third_out;
    logic [VALUE_W-1:0] fourth_out;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL_DBL,
    PH_MUL_ADD,
    PH_ALU,
    PH_RT_A,
    PH_RT_B,
    PH_CRT,
    PH_DONE
  } phase_t;

  typedef enum logic [4:0] {
    ST_N, ST_BM, ST_VM, ST_ENC_W, ST_ENC_C,
    ST_INV2, ST_INV4, ST_BB, ST_U, ST_T,
    ST_TP, ST_RP, ST_TQ, ST_RQ, ST_AQ, ST_PQ,
    ST_C1, ST_K1, ST_X1, ST_C2, ST_K2, ST_X2,
    ST_H, ST_O0, ST_O1, ST_W2, ST_O2, ST_W3, ST_O3
  } step_t;

endpackage

FILE: src/rabin_alu.sv
// rabin_alu: the shared modular add / subtract unit.
// Depends on rabin_pkg (alu_op_t). Operands must lie in [0, m].
`timescale 1ns / 1ps

module rabin_alu #(
  parameter int W = 25
) (
  input  rabin_pkg::alu_op_t op,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  input  logic [W-1:0]       m,
  output logic [W-1:0]       y
);

  logic [W:0] sum;
  logic [W:0] dif;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    dif = {1'b0, a} - {1'b0, b};
    unique case (op)
      rabin_pkg::ALU_ADD: y = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
      rabin_pkg::ALU_SUB: y = (a >= b) ? dif[W-1:0] : W'(dif + {1'b0, m});
      default:            y = '0;
    endcase
  end

endmodule

FILE: src/rabin_core.sv
// rabin_core: sequencer and working registers; runs every step on one rabin_alu.
// Depends on rabin_pkg and rabin_alu.
`timescale 1ns / 1ps

module rabin_core #(
  parameter int PRIME_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  rabin_pkg::in_word_t                in_word,
  input  logic [PRIME_BITS-1:0]              prime_p,
  input  logic [PRIME_BITS-1:0]              prime_q,
  input  logic [rabin_pkg::VALUE_W-1:0]      offset_b,
  output rabin_pkg::core_stat_t              stat,
  output rabin_pkg::out_word_t               result
);

  localparam int PB   = PRIME_BITS;
  localparam int NW   = 2 * PRIME_BITS;
  localparam int W    = NW + 1;
  localparam int YW   = (NW > rabin_pkg::VALUE_W) ? NW : rabin_pkg::VALUE_W;
  localparam int BC_W = $clog2(YW);
  localparam logic [W-1:0] MAX = '1;

  rabin_pkg::phase_t phase_r, phase_nxt;
  rabin_pkg::step_t  step_r, step_nxt;

  logic                          cmd_r, cmd_nxt;
  logic [rabin_pkg::VALUE_W-1:0] v_r, v_nxt;
  logic [W-1:0] n_r, n_nxt, bm_r, bm_nxt, vm_r, vm_nxt, inv2_r, inv2_nxt;
  logic [W-1:0] tmp_r, tmp_nxt, t_r, t_nxt, h_r, h_nxt;
  logic [W-1:0] s1_r, s1_nxt, s2_r, s2_nxt, acc_r, acc_nxt;
  logic [W-1:0] o0_r, o0_nxt, o1_r, o1_nxt, o2_r, o2_nxt, o3_r, o3_nxt;
  logic [PB-1:0] tgt_r, tgt_nxt, p1_r, p1_nxt, q1_r, q1_nxt, q2_r, q2_nxt;
  logic [PB-1:0] aq_r, aq_nxt, pq_r, pq_nxt;
  logic [PB-1:0] i_r, i_nxt, sq_r, sq_nxt, xr_r, xr_nxt, k_r, k_nxt;
  logic          found_r, found_nxt;
  logic [BC_W-1:0] bcnt_r, bcnt_nxt;

  // operand selection
  logic [W-1:0]  mx, mm, one_n, one_p, one_q, msrch;
  logic [YW-1:0] my;
  logic [PB-1:0] msrch_pb, crt_b, q1_new, q2_new;
  logic [PB:0]   i_inc;
  logic          hit, last_i, found_new, fin, launch;
  rabin_pkg::step_t   launch_step;
  rabin_pkg::alu_op_t uop;
  logic [W-1:0]  ua, ub, um, uy;

  assign one_n    = (n_r == W'(1)) ? '0 : W'(1);
  assign one_p    = (prime_p == PB'(1)) ? '0 : W'(1);
  assign one_q    = (prime_q == PB'(1)) ? '0 : W'(1);
  assign msrch_pb = (step_r == rabin_pkg::ST_RP) ? prime_p : prime_q;
  assign msrch    = W'(msrch_pb);
  assign i_inc    = {1'b0, i_r} + 1'b1;
  assign hit      = (sq_r == tgt_r);
  assign last_i   = (i_r == msrch_pb - 1'b1);
  assign crt_b    = (step_r == rabin_pkg::ST_C1) ? q1_r : q2_r;

  rabin_alu #(.W(W)) u_alu (
    .op (uop),
    .a  (ua),
    .b  (ub),
    .m  (um),
    .y  (uy)
  );

  // multiplicand, multiplier and modulus of the running product
  always_comb begin : mul_opnd
    mx = '0;
    my = '0;
    mm = n_r;
    unique case (step_r)
      rabin_pkg::ST_N:     begin mx = W'(prime_p); my = YW'(prime_q); mm = MAX; end
      rabin_pkg::ST_BM:    begin mx = one_n; my = YW'(offset_b); end
      rabin_pkg::ST_VM:    begin mx = one_n; my = YW'(v_r); end
      rabin_pkg::ST_ENC_C: begin mx = vm_r; my = YW'(tmp_r); end
      rabin_pkg::ST_INV4:  begin mx = inv2_r; my = YW'(inv2_r); end
      rabin_pkg::ST_BB:    begin mx = bm_r; my = YW'(bm_r); end
      rabin_pkg::ST_U:     begin mx = tmp_r; my = YW'(t_r); end
      rabin_pkg::ST_TP:    begin mx = one_p; my = YW'(t_r); mm = W'(prime_p); end
      rabin_pkg::ST_TQ:    begin mx = one_q; my = YW'(t_r); mm = W'(prime_q); end
      rabin_pkg::ST_AQ:    begin mx = one_q; my = YW'(p1_r); mm = W'(prime_q); end
      rabin_pkg::ST_PQ:    begin mx = one_q; my = YW'(prime_p); mm = W'(prime_q); end
      rabin_pkg::ST_K1,
      rabin_pkg::ST_K2:    begin mx = W'(prime_p); my = YW'(k_r); mm = MAX; end
      rabin_pkg::ST_H:     begin mx = bm_r; my = YW'(inv2_r); end
      default: ;
    endcase
  end

  // shared unit inputs
  always_comb begin : unit_sel
    uop = rabin_pkg::ALU_ADD;
    ua  = '0;
    ub  = '0;
    um  = MAX;
    unique case (phase_r)
      rabin_pkg::PH_MUL_DBL: begin ua = acc_r; ub = acc_r; um = mm; end
      rabin_pkg::PH_MUL_ADD: begin
        ua = acc_r;
        ub = my[bcnt_r] ? mx : '0;
        um = mm;
      end
      rabin_pkg::PH_ALU: begin
        um = n_r;
        unique case (step_r)
          rabin_pkg::ST_ENC_W: begin ua = vm_r; ub = bm_r; end
          rabin_pkg::ST_INV2:  begin ua = {1'b0, n_r[W-1:1]}; ub = W'(1); end
          rabin_pkg::ST_T:     begin ua = tmp_r; ub = vm_r; end
          rabin_pkg::ST_X1,
          rabin_pkg::ST_X2:    begin ua = tmp_r; ub = W'(p1_r); um = MAX; end
          rabin_pkg::ST_O0:    begin uop = rabin_pkg::ALU_SUB; ua = s1_r; ub = h_r; end
          rabin_pkg::ST_O1:    begin uop = rabin_pkg::ALU_SUB; ua = s2_r; ub = h_r; end
          rabin_pkg::ST_W2:    begin uop = rabin_pkg::ALU_SUB; ua = n_r; ub = s1_r; end
          rabin_pkg::ST_W3:    begin uop = rabin_pkg::ALU_SUB; ua = n_r; ub = s2_r; end
          rabin_pkg::ST_O2,
          rabin_pkg::ST_O3:    begin uop = rabin_pkg::ALU_SUB; ua = tmp_r; ub = h_r; end
          default: ;
        endcase
      end
      rabin_pkg::PH_RT_A: begin ua = W'(sq_r); ub = W'(i_r); um = msrch; end
      rabin_pkg::PH_RT_B: begin ua = W'(sq_r); ub = W'(i_inc); um = msrch; end
      rabin_pkg::PH_CRT:  begin ua = W'(xr_r); ub = W'(pq_r); um = W'(prime_q); end
      default: ;
    endcase
  end

  always_comb begin : ctrl
    phase_nxt = phase_r;   step_nxt = step_r;
    cmd_nxt = cmd_r;       v_nxt = v_r;
    n_nxt = n_r;           bm_nxt = bm_r;       vm_nxt = vm_r;     inv2_nxt = inv2_r;
    tmp_nxt = tmp_r;       t_nxt = t_r;         h_nxt = h_r;
    s1_nxt = s1_r;         s2_nxt = s2_r;       acc_nxt = acc_r;
    o0_nxt = o0_r;         o1_nxt = o1_r;       o2_nxt = o2_r;     o3_nxt = o3_r;
    tgt_nxt = tgt_r;       p1_nxt = p1_r;       q1_nxt = q1_r;     q2_nxt = q2_r;
    aq_nxt = aq_r;         pq_nxt = pq_r;
    i_nxt = i_r;           sq_nxt = sq_r;       xr_nxt = xr_r;     k_nxt = k_r;
    found_nxt = found_r;   bcnt_nxt = bcnt_r;
    q1_new = q1_r;         q2_new = q2_r;       found_new = found_r;
    fin = 1'b0;
    launch = 1'b0;
    launch_step = step_r;

    unique case (phase_r)
      rabin_pkg::PH_IDLE: begin
        if (start) begin
          cmd_nxt = in_word.command;
          v_nxt   = in_word.value;
          if (prime_p == '0 || prime_q == '0) begin
            // zero modulus: all fields zero
            o0_nxt = '0; o1_nxt = '0; o2_nxt = '0; o3_nxt = '0;
            phase_nxt = rabin_pkg::PH_DONE;
          end else begin
            launch = 1'b1;
            launch_step = rabin_pkg::ST_N;
          end
        end
      end
      rabin_pkg::PH_MUL_DBL: begin
        acc_nxt = uy;
        phase_nxt = rabin_pkg::PH_MUL_ADD;
      end
      rabin_pkg::PH_MUL_ADD: begin
        acc_nxt = uy;
        if (bcnt_r == '0) begin
          fin = 1'b1;
        end else begin
          bcnt_nxt = bcnt_r - 1'b1;
          phase_nxt = rabin_pkg::PH_MUL_DBL;
        end
      end
      rabin_pkg::PH_ALU: fin = 1'b1;
      rabin_pkg::PH_RT_A: begin
        if (step_r == rabin_pkg::ST_RP) begin
          // only the first root mod p is needed
          if (hit || last_i) begin
            if (hit) p1_nxt = i_r;
            launch = 1'b1;
            launch_step = rabin_pkg::ST_TQ;
          end else begin
            sq_nxt = uy[PB-1:0];
            phase_nxt = rabin_pkg::PH_RT_B;
          end
        end else begin
          if (hit) begin
            if (!found_r) begin
              q1_new = i_r;
              found_new = 1'b1;
            end else begin
              q2_new = i_r;
            end
          end
          q1_nxt = q1_new;
          q2_nxt = q2_new;
          found_nxt = found_new;
          if (last_i) begin
            // single root: last equals first
            if (q2_new == '0) q2_nxt = q1_new;
            launch = 1'b1;
            launch_step = rabin_pkg::ST_AQ;
          end else begin
            sq_nxt = uy[PB-1:0];
            phase_nxt = rabin_pkg::PH_RT_B;
          end
        end
      end
      rabin_pkg::PH_RT_B: begin
        sq_nxt = uy[PB-1:0];
        i_nxt = i_r + 1'b1;
        phase_nxt = rabin_pkg::PH_RT_A;
      end
      rabin_pkg::PH_CRT: begin
        launch = 1'b1;
        if (xr_r == crt_b) begin
          launch_step = (step_r == rabin_pkg::ST_C1) ? rabin_pkg::ST_K1 : rabin_pkg::ST_K2;
        end else if (k_r == prime_q - 1'b1) begin
          // no joint solution
          if (step_r == rabin_pkg::ST_C1) begin
            s1_nxt = '0;
            launch_step = rabin_pkg::ST_C2;
          end else begin
            s2_nxt = '0;
            launch_step = rabin_pkg::ST_H;
          end
        end else begin
          launch = 1'b0;
          xr_nxt = uy[PB-1:0];
          k_nxt = k_r + 1'b1;
        end
      end
      rabin_pkg::PH_DONE: phase_nxt = rabin_pkg::PH_IDLE;
      default: phase_nxt = rabin_pkg::PH_IDLE;
    endcase

    // write back the finished step and pick the next
    if (fin) begin
      launch = 1'b1;
      unique case (step_r)
        rabin_pkg::ST_N:     begin n_nxt = uy; launch_step = rabin_pkg::ST_BM; end
        rabin_pkg::ST_BM:    begin bm_nxt = uy; launch_step = rabin_pkg::ST_VM; end
        rabin_pkg::ST_VM: begin
          vm_nxt = uy;
          launch_step = (cmd_r == rabin_pkg::CMD_ENCRYPT) ? rabin_pkg::ST_ENC_W
                                                          : rabin_pkg::ST_INV2;
        end
        rabin_pkg::ST_ENC_W: begin tmp_nxt = uy; launch_step = rabin_pkg::ST_ENC_C; end
        rabin_pkg::ST_ENC_C: begin
          o0_nxt = uy; o1_nxt = '0; o2_nxt = '0; o3_nxt = '0;
          launch = 1'b0;
          phase_nxt = rabin_pkg::PH_DONE;
        end
        rabin_pkg::ST_INV2: begin
          // inverse of 2 exists only for odd n above 1
          inv2_nxt = (n_r[0] && n_r != W'(1)) ? uy : '0;
          launch_step = rabin_pkg::ST_INV4;
        end
        rabin_pkg::ST_INV4:  begin t_nxt = uy; launch_step = rabin_pkg::ST_BB; end
        rabin_pkg::ST_BB:    begin tmp_nxt = uy; launch_step = rabin_pkg::ST_U; end
        rabin_pkg::ST_U:     begin tmp_nxt = uy; launch_step = rabin_pkg::ST_T; end
        rabin_pkg::ST_T:     begin t_nxt = uy; launch_step = rabin_pkg::ST_TP; end
        rabin_pkg::ST_TP:    begin tgt_nxt = uy[PB-1:0]; launch_step = rabin_pkg::ST_RP; end
        rabin_pkg::ST_TQ:    begin tgt_nxt = uy[PB-1:0]; launch_step = rabin_pkg::ST_RQ; end
        rabin_pkg::ST_AQ:    begin aq_nxt = uy[PB-1:0]; launch_step = rabin_pkg::ST_PQ; end
        rabin_pkg::ST_PQ:    begin pq_nxt = uy[PB-1:0]; launch_step = rabin_pkg::ST_C1; end
        rabin_pkg::ST_K1:    begin tmp_nxt = uy; launch_step = rabin_pkg::ST_X1; end
        rabin_pkg::ST_X1:    begin s1_nxt = uy; launch_step = rabin_pkg::ST_C2; end
        rabin_pkg::ST_K2:    begin tmp_nxt = uy; launch_step = rabin_pkg::ST_X2; end
        rabin_pkg::ST_X2:    begin s2_nxt = uy; launch_step = rabin_pkg::ST_H; end
        rabin_pkg::ST_H:     begin h_nxt = uy; launch_step = rabin_pkg::ST_O0; end
        rabin_pkg::ST_O0:    begin o0_nxt = uy; launch_step = rabin_pkg::ST_O1; end
        rabin_pkg::ST_O1:    begin o1_nxt = uy; launch_step = rabin_pkg::ST_W2; end
        rabin_pkg::ST_W2:    begin tmp_nxt = uy; launch_step = rabin_pkg::ST_O2; end
        rabin_pkg::ST_O2:    begin o2_nxt = uy; launch_step = rabin_pkg::ST_W3; end
        rabin_pkg::ST_W3:    begin tmp_nxt = uy; launch_step = rabin_pkg::ST_O3; end
        rabin_pkg::ST_O3: begin
          o3_nxt = uy;
          launch = 1'b0;
          phase_nxt = rabin_pkg::PH_DONE;
        end
        default: launch = 1'b0;
      endcase
    end

    // set up the next step
    if (launch) begin
      step_nxt = launch_step;
      unique case (launch_step)
        rabin_pkg::ST_RP,
        rabin_pkg::ST_RQ: begin
          phase_nxt = rabin_pkg::PH_RT_A;
          i_nxt = '0;
          sq_nxt = '0;
          found_nxt = 1'b0;
          if (launch_step == rabin_pkg::ST_RP) begin
            p1_nxt = '0;
          end else begin
            q1_nxt = '0;
            q2_nxt = '0;
          end
        end
        rabin_pkg::ST_C1,
        rabin_pkg::ST_C2: begin
          phase_nxt = rabin_pkg::PH_CRT;
          xr_nxt = aq_r;
          k_nxt = '0;
        end
        rabin_pkg::ST_ENC_W, rabin_pkg::ST_INV2, rabin_pkg::ST_T,
        rabin_pkg::ST_X1, rabin_pkg::ST_X2, rabin_pkg::ST_O0, rabin_pkg::ST_O1,
        rabin_pkg::ST_W2, rabin_pkg::ST_O2, rabin_pkg::ST_W3, rabin_pkg::ST_O3: begin
          phase_nxt = rabin_pkg::PH_ALU;
        end
        default: begin
          phase_nxt = rabin_pkg::PH_MUL_DBL;
          acc_nxt = '0;
          bcnt_nxt = BC_W'(YW - 1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rabin_pkg::PH_IDLE;
      step_r  <= rabin_pkg::ST_N;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;   v_r <= v_nxt;
    n_r <= n_nxt;       bm_r <= bm_nxt;     vm_r <= vm_nxt;   inv2_r <= inv2_nxt;
    tmp_r <= tmp_nxt;   t_r <= t_nxt;       h_r <= h_nxt;
    s1_r <= s1_nxt;     s2_r <= s2_nxt;     acc_r <= acc_nxt;
    o0_r <= o0_nxt;     o1_r <= o1_nxt;     o2_r <= o2_nxt;   o3_r <= o3_nxt;
    tgt_r <= tgt_nxt;   p1_r <= p1_nxt;     q1_r <= q1_nxt;   q2_r <= q2_nxt;
    aq_r <= aq_nxt;     pq_r <= pq_nxt;
    i_r <= i_nxt;       sq_r <= sq_nxt;     xr_r <= xr_nxt;   k_r <= k_nxt;
    found_r <= found_nxt;
    bcnt_r <= bcnt_nxt;
  end

  assign stat.busy = (phase_r != rabin_pkg::PH_IDLE);
  assign stat.done = (phase_r == rabin_pkg::PH_DONE);

  assign result.first_out  = rabin_pkg::VALUE_W'(o0_r);
  assign result.second_out = rabin_pkg::VALUE_W'(o1_r);
  assign result.third_out  = rabin_pkg::VALUE_W'(o2_r);
  assign result.fourth_out = rabin_pkg::VALUE_W'(o3_r);

endmodule

FILE: src/rabin_encrypt_decrypt.sv
// rabin_encrypt_decrypt: top level of the offset Rabin cipher (encrypt / decrypt).
// Depends on rabin_pkg and rabin_core (which holds rabin_alu).
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+------------------------------------
//   input    | start, busy, in_data           | word taken when start && !busy
//   result   | out_strobe, out_data           | one-cycle strobe, cannot be held off
//   config   | cfg_we, cfg_index, cfg_wdata   | written on any edge with cfg_we
//
// All arithmetic runs on one modular add/sub unit. A modular product walks the
// multiplier MSB first, with a double step and an add step per bit, over
// YW = max(24, 2*PRIME_BITS) bits. Decrypt also runs square-root scans over the
// candidate roots and CRT scans modulo q. Zero prime: the core skips all
// arithmetic and goes straight to its done state, which the result register
// turns into the strobe.
// Reset (rst_n low, synchronous) idles the sequencer and loads p = 3, q = 7, b = 0.
// busy is high from the word after acceptance until the result is out; a new word
// may be given in the cycle the strobe is shown.
`timescale 1ns / 1ps

module rabin_encrypt_decrypt #(
  parameter int PRIME_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  rabin_pkg::in_word_t                 in_data,
  output logic                                out_strobe,
  output rabin_pkg::out_word_t                out_data,
  input  logic                                cfg_we,
  input  logic [rabin_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [((PRIME_BITS > rabin_pkg::VALUE_W) ? PRIME_BITS
                                                   : rabin_pkg::VALUE_W)-1:0] cfg_wdata
);

  logic [PRIME_BITS-1:0]         prime_p_r;
  logic [PRIME_BITS-1:0]         prime_q_r;
  logic [rabin_pkg::VALUE_W-1:0] offset_b_r;

  rabin_pkg::core_stat_t stat;
  rabin_pkg::out_word_t  result;
  logic                  out_strobe_r;
  rabin_pkg::out_word_t  out_data_r;

  // config registers; write them only while idle, a rule on the user that the block leaves unchecked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_p_r  <= PRIME_BITS'(rabin_pkg::PRIME_P_RST);
      prime_q_r  <= PRIME_BITS'(rabin_pkg::PRIME_Q_RST);
      offset_b_r <= rabin_pkg::VALUE_W'(rabin_pkg::OFFSET_B_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rabin_pkg::CFG_PRIME_P:  prime_p_r  <= cfg_wdata[PRIME_BITS-1:0];
        rabin_pkg::CFG_PRIME_Q:  prime_q_r  <= cfg_wdata[PRIME_BITS-1:0];
        rabin_pkg::CFG_OFFSET_B: offset_b_r <= cfg_wdata[rabin_pkg::VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  rabin_core #(.PRIME_BITS(PRIME_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_word  (in_data),
    .prime_p  (prime_p_r),
    .prime_q  (prime_q_r),
    .offset_b (offset_b_r),
    .stat     (stat),
    .result   (result)
  );

  // result register: frees the core as soon as the word is out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data_r <= result;
    end
  end

  assign busy       = stat.busy;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // a taken word keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after a word was taken");

  // one result per word
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // a result only follows work in progress
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

endmodule
